[design/ulbp_pkg.sv]
package ulbp_pkg;

	localparam int PIX_W = 16;
	localparam int CX_W  = 14;
	localparam int CY_W  = 14;
	localparam int REM_W = 10;
	localparam int BIN_W = 6;

	localparam logic [7:0] REG_IMAGE_WIDTH     = 8'd0;
	localparam logic [7:0] REG_IMAGE_HEIGHT    = 8'd1;
	localparam logic [7:0] REG_CELL_SIZE       = 8'd2;
	localparam logic [7:0] REG_TRANSPOSED_MODE = 8'd3;

	localparam logic [BIN_W-1:0] BIN_CONSTANT = 6'd56;
	localparam logic [BIN_W-1:0] BIN_OTHER    = 6'd57;
	localparam int RUN_LENGTHS = 7;

	typedef struct packed {
		logic [7:0]             code;
		logic signed [CX_W-1:0] qx;
		logic [REM_W-1:0]       rx;
		logic signed [CY_W-1:0] qy;
		logic [REM_W-1:0]       ry;
	} job_t;

	// Map an 8-bit pattern to its uniform bin; transposed patterns are
	// undone first (rotate right by 3, then reverse the bit order).
	function automatic logic [BIN_W-1:0] lbp_bin(input logic [7:0] code, input logic transp);
		logic [7:0] r;
		logic [7:0] s;
		logic [3:0] trans;
		logic [3:0] ones;
		logic [2:0] lead;
		begin
			r = {code[2:0], code[7:3]};
			for (int k = 0; k < 8; k++) begin
				s[k] = transp ? r[7-k] : code[k];
			end
			trans = '0;
			ones = '0;
			lead = '0;
			for (int k = 0; k < 8; k++) begin
				trans = trans + 4'(s[k] ^ s[(k+1)%8]);
				ones = ones + 4'(s[k]);
				if (s[k] && !s[(k+7)%8]) begin
					lead = 3'(k);
				end
			end
			if (s == 8'h00 || s == 8'hff) begin
				lbp_bin = BIN_CONSTANT;
			end else if (trans != 4'd2) begin
				lbp_bin = BIN_OTHER;
			end else begin
				lbp_bin = 6'(6'(lead) * 6'(RUN_LENGTHS) + 6'(ones) - 6'd1);
			end
		end
	endfunction

endpackage

[design/ulbp_front.sv]
module ulbp_front #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pix_valid,
	output logic                        pix_ready,
	input  logic [ulbp_pkg::PIX_W-1:0]  pix,
	input  logic [10:0]                 w_eff,
	input  logic [12:0]                 h_eff,
	input  logic [8:0]                  c_eff,
	output logic                        job_valid,
	input  logic                        job_ready,
	output ulbp_pkg::job_t              job
);
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int PW = ulbp_pkg::PIX_W;

	logic [2*PW-1:0] mem [MAX_WIDTH];
	logic [2*PW-1:0] rd_q;

	logic [AW-1:0] col_q;
	logic [11:0]   row_q;
	logic signed [ulbp_pkg::CX_W-1:0] qx_q;
	logic signed [ulbp_pkg::CY_W-1:0] qy_q;
	logic [ulbp_pkg::REM_W-1:0] rx_q, ry_q;

	logic          v_s1;
	logic [PW-1:0] cur_s1;
	logic [AW-1:0] col_s1;
	logic [11:0]   row_s1;
	logic signed [ulbp_pkg::CX_W-1:0] qx_s1;
	logic signed [ulbp_pkg::CY_W-1:0] qy_s1;
	logic [ulbp_pkg::REM_W-1:0] rx_s1, ry_s1;

	logic [PW-1:0] win_q [6];

	logic accept, adv_s1, emit, interior, fit_x, fit_y, col_wrap, row_wrap;
	logic [PW-1:0] up, mid, ctr;
	logic [7:0] code;
	logic [9:0] dd;
	logic [ulbp_pkg::REM_W:0] rx_n, ry_n;
	logic [ulbp_pkg::REM_W-1:0] init_r;
	logic init_norm;
	logic [22:0] prod_x, prod_y;

	assign dd = {c_eff, 1'b0};
	assign accept = pix_valid && pix_ready;
	assign up = rd_q[2*PW-1:PW];
	assign mid = rd_q[PW-1:0];
	assign ctr = win_q[4];

	always_comb begin
		interior = (col_s1 >= AW'(2)) && (row_s1 >= 12'd2)
			&& (32'(col_s1) < 32'(w_eff)) && (32'(row_s1) < 32'(h_eff));
		prod_x = 23'(14'(qx_s1 + 14'sd1) * c_eff);
		prod_y = 23'(14'(qy_s1 + 14'sd1) * c_eff);
		fit_x = prod_x <= 23'(w_eff);
		fit_y = prod_y <= 23'(h_eff);
		emit = v_s1 && interior && fit_x && fit_y;
		adv_s1 = v_s1 && (!emit || job_ready);
		pix_ready = !v_s1 || adv_s1;
		job_valid = emit;
		code[0] = mid > ctr;
		code[1] = cur_s1 > ctr;
		code[2] = win_q[5] > ctr;
		code[3] = win_q[2] > ctr;
		code[4] = win_q[1] > ctr;
		code[5] = win_q[0] > ctr;
		code[6] = win_q[3] > ctr;
		code[7] = up > ctr;
		job.code = code;
		job.qx = qx_s1;
		job.rx = rx_s1;
		job.qy = qy_s1;
		job.ry = ry_s1;
		col_wrap = 32'(col_q) + 32'd1 >= 32'(w_eff);
		row_wrap = 32'(row_q) + 32'd1 >= 32'(h_eff);
		init_norm = c_eff == 9'd1;
		init_r = init_norm ? '0 : ulbp_pkg::REM_W'(c_eff) + 10'd1;
		rx_n = 11'(rx_q) + 11'd2;
		ry_n = 11'(ry_q) + 11'd2;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= mem[col_q];
		end
		if (adv_s1) begin
			mem[col_s1] <= {mid, cur_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1 <= pix;
			col_s1 <= col_q;
			row_s1 <= row_q;
			qx_s1 <= qx_q;
			qy_s1 <= qy_q;
			rx_s1 <= rx_q;
			ry_s1 <= ry_q;
		end
		if (adv_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= up;
			win_q[4] <= mid;
			win_q[5] <= cur_s1;
		end
	end

	// Raster position plus running quotient/remainder of (2p+1-c)/(2c).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			col_q <= '0;
			row_q <= '0;
			qx_q <= '0;
			qy_q <= '0;
			rx_q <= '0;
			ry_q <= '0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (accept) begin
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? 12'd0 : row_q + 12'd1;
					if (!row_wrap) begin
						if (row_q == 12'd0) begin
							qy_q <= init_norm ? 14'sd0 : -14'sd1;
							ry_q <= init_r;
						end else if (ry_n >= 11'(dd)) begin
							qy_q <= qy_q + 14'sd1;
							ry_q <= ulbp_pkg::REM_W'(ry_n - 11'(dd));
						end else begin
							ry_q <= ulbp_pkg::REM_W'(ry_n);
						end
					end
				end else begin
					col_q <= col_q + AW'(1);
					if (col_q == '0) begin
						qx_q <= init_norm ? 14'sd0 : -14'sd1;
						rx_q <= init_r;
					end else if (rx_n >= 11'(dd)) begin
						qx_q <= qx_q + 14'sd1;
						rx_q <= ulbp_pkg::REM_W'(rx_n - 11'(dd));
					end else begin
						rx_q <= ulbp_pkg::REM_W'(rx_n);
					end
				end
			end
		end
	end
endmodule

[design/ulbp_queue.sv]
module ulbp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  ulbp_pkg::job_t wr_job,
	output logic           rd_valid,
	input  logic           rd_ready,
	output ulbp_pkg::job_t rd_job
);
	ulbp_pkg::job_t slot_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic push, pop;

	assign wr_ready = cnt_q != 3'd4;
	assign rd_valid = cnt_q != 3'd0;
	assign rd_job = slot_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 2'd1;
			end
			if (pop) begin
				rp_q <= rp_q + 2'd1;
			end
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end
endmodule

[design/ulbp_back.sv]
module ulbp_back #(
	parameter int WEIGHT_FRAC_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         job_valid,
	output logic                         job_ready,
	input  ulbp_pkg::job_t               job,
	input  logic [8:0]                   c_eff,
	input  logic                         transp,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ulbp_pkg::BIN_W-1:0]   out_bin,
	output logic [10:0]                  out_cx,
	output logic [12:0]                  out_cy,
	output logic [WEIGHT_FRAC_BITS-1:0]  out_wx,
	output logic [WEIGHT_FRAC_BITS-1:0]  out_wy
);
	localparam int NW = WEIGHT_FRAC_BITS;
	localparam int SW = (NW > 1) ? $clog2(NW) : 1;
	localparam int RW = ulbp_pkg::REM_W;
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0] state_q;
	logic [SW-1:0] step_q;
	logic [RW-1:0] remx_q, remy_q, d_q;
	logic [NW-1:0] wx_q, wy_q;
	logic [ulbp_pkg::BIN_W-1:0] bin_q;
	logic [10:0] cx_q;
	logic [12:0] cy_q;
	logic [RW:0] tx, ty;
	logic out_free;

	assign job_ready = state_q == ST_IDLE;
	assign out_free = !out_valid || out_ready;
	assign tx = {remx_q, 1'b0};
	assign ty = {remy_q, 1'b0};

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				remx_q <= job.rx;
				remy_q <= job.ry;
				d_q <= {c_eff, 1'b0};
				bin_q <= ulbp_pkg::lbp_bin(job.code, transp);
				cx_q <= job.qx[10:0];
				cy_q <= job.qy[12:0];
			end
			ST_DIV: begin
				if (tx >= (RW+1)'(d_q)) begin
					remx_q <= RW'(tx - (RW+1)'(d_q));
					wx_q <= {wx_q[NW-2:0], 1'b1};
				end else begin
					remx_q <= RW'(tx);
					wx_q <= {wx_q[NW-2:0], 1'b0};
				end
				if (ty >= (RW+1)'(d_q)) begin
					remy_q <= RW'(ty - (RW+1)'(d_q));
					wy_q <= {wy_q[NW-2:0], 1'b1};
				end else begin
					remy_q <= RW'(ty);
					wy_q <= {wy_q[NW-2:0], 1'b0};
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					out_bin <= bin_q;
					out_cx <= cx_q;
					out_cy <= cy_q;
					out_wx <= wx_q;
					out_wy <= wy_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (job_valid) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + SW'(1);
					if (step_q == SW'(NW - 1)) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

[design/uniform_lbp_code_with_cell_weights.sv]
// A result passes the front window register, the queue, the back load, the weight divider
// (one bit per cycle) and the output register before it is valid.
// Throughput: one pixel per cycle while the queue has room; each result item
// occupies the shared weight divider until it is passed to the output register, a 4-deep queue
// absorbs bursts. Reset clears counters, queue and valids; registers return to
// 640 x 480, cell 8, normal mode. Line stores need no clearing pass.
module uniform_lbp_code_with_cell_weights #(
	parameter int MAX_WIDTH        = 1024,
	parameter int WEIGHT_FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [12:0] cfg_data,
	// pixel stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] pixel
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// from bit 0: bin(6), cell_col_low(11), cell_row_low(13), weight_col_high,
	// weight_row_high (WEIGHT_FRAC_BITS each), zero fill to whole bytes
	output logic [((30 + 2*WEIGHT_FRAC_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);
	localparam int OUT_W = ((30 + 2*WEIGHT_FRAC_BITS + 7) / 8) * 8;

	logic [10:0] image_width_q;
	logic [12:0] image_height_q;
	logic [8:0]  cell_size_q;
	logic        transposed_mode_q;

	logic [10:0] w_eff;
	logic [12:0] h_eff;
	logic [8:0]  c_eff;

	ulbp_pkg::job_t f_job, q_job;
	logic f_valid, f_ready, q_valid, q_ready;

	logic [ulbp_pkg::BIN_W-1:0] o_bin;
	logic [10:0] o_cx;
	logic [12:0] o_cy;
	logic [WEIGHT_FRAC_BITS-1:0] o_wx, o_wy;

	assign cfg_ready = 1'b1;

	// Saturate the geometry registers to their legal ranges.
	always_comb begin
		if (image_width_q < 11'd3) begin
			w_eff = 11'd3;
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			w_eff = 11'(MAX_WIDTH);
		end else begin
			w_eff = image_width_q;
		end
		h_eff = (image_height_q < 13'd3) ? 13'd3
			: (image_height_q > 13'd4096) ? 13'd4096 : image_height_q;
		c_eff = (cell_size_q == 9'd0) ? 9'd1
			: (cell_size_q > 9'd256) ? 9'd256 : cell_size_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= 11'd640;
			image_height_q <= 13'd480;
			cell_size_q <= 9'd8;
			transposed_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ulbp_pkg::REG_IMAGE_WIDTH:     image_width_q <= cfg_data[10:0];
				ulbp_pkg::REG_IMAGE_HEIGHT:    image_height_q <= cfg_data;
				ulbp_pkg::REG_CELL_SIZE:       cell_size_q <= cfg_data[8:0];
				ulbp_pkg::REG_TRANSPOSED_MODE: transposed_mode_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Front: window, pattern and cell tracking.
	ulbp_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(s_axis_tvalid), .pix_ready(s_axis_tready), .pix(s_axis_tdata),
		.w_eff(w_eff), .h_eff(h_eff), .c_eff(c_eff),
		.job_valid(f_valid), .job_ready(f_ready), .job(f_job)
	);

	// Decouple front and back so each can stall on its own.
	ulbp_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_job(f_job),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_job(q_job)
	);

	// Back: bin mapping and bilinear weight division.
	ulbp_back #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(q_valid), .job_ready(q_ready), .job(q_job),
		.c_eff(c_eff), .transp(transposed_mode_q),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_bin(o_bin), .out_cx(o_cx), .out_cy(o_cy), .out_wx(o_wx), .out_wy(o_wy)
	);

	assign m_axis_tdata = OUT_W'({o_wy, o_wx, o_cy, o_cx, o_bin});
endmodule

[design/ulbp_checker.sv]
module ulbp_checker #(
	parameter int DATA_W = 48
) (
	input logic              clk,
	input logic              arst_n,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [DATA_W-1:0] m_axis_tdata
);
	// bin never exceeds the "other" code
	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[5:0] <= ulbp_pkg::BIN_OTHER))
		else $error("bin out of range");

	// lower cell column is -1 or non-negative
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (!m_axis_tdata[16] || m_axis_tdata[16:6] == 11'h7ff))
		else $error("cell column below -1");

	// lower cell row is -1 or non-negative
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (!m_axis_tdata[29] || m_axis_tdata[29:17] == 13'h1fff))
		else $error("cell row below -1");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
endmodule

bind uniform_lbp_code_with_cell_weights ulbp_checker #(.DATA_W(OUT_W)) u_ulbp_checker (
	.clk(clk), .arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

[test/uniform_lbp_code_with_cell_weights_tb.sv]
`timescale 1ns / 1ps

module uniform_lbp_code_with_cell_weights_tb;

	localparam int OUT_W = ((30 + 2*8 + 7) / 8) * 8;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [5:0]         bin;
		logic signed [10:0] cell_col_low;
		logic signed [12:0] cell_row_low;
		logic [7:0]         weight_col_high;
		logic [7:0]         weight_row_high;
	} lbp_result_t;

	// Scoreboard: keeps its own copy of the raster state, predicts the result
	// of each accepted pixel and compares results in order.
	class lbp_scoreboard;
		bit [15:0] upper_row [1024];
		bit [15:0] middle_row [1024];
		bit [15:0] win [6];
		int unsigned col_pos, row_pos;
		int unsigned width_reg, height_reg, cell_reg;
		bit transposed;
		lbp_result_t pending [$];
		int unsigned mismatches, results_seen;

		function void clear();
			col_pos = 0;
			row_pos = 0;
			width_reg = 640;
			height_reg = 480;
			cell_reg = 8;
			transposed = 0;
			pending.delete();
		endfunction

		function void write_reg(logic [7:0] idx, logic [12:0] val);
			case (idx)
				ulbp_pkg::REG_IMAGE_WIDTH: width_reg = val[10:0];
				ulbp_pkg::REG_IMAGE_HEIGHT: height_reg = val[12:0];
				ulbp_pkg::REG_CELL_SIZE: cell_reg = val[8:0];
				ulbp_pkg::REG_TRANSPOSED_MODE: transposed = val[0];
				default: ;
			endcase
		endfunction

		static function int unsigned sat(int unsigned v, int unsigned lo, int unsigned hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		// Run of `ones` set bits starting at rotation `lead`, as laid out in the
		// chosen mode.
		static function bit [7:0] run_pattern(int lead, int ones, bit tr);
			bit [15:0] s;
			bit [7:0] p, r;
			s = ((16'd1 << ones) - 1) << lead;
			p = s[7:0] | s[15:8];
			if (!tr) return p;
			for (int k = 0; k < 8; k++) r[7-k] = p[k];
			return {r[4:0], r[7:5]};
		endfunction

		static function bit [5:0] uniform_bin(bit [7:0] code, bit tr);
			if (code == 8'h00 || code == 8'hff) return ulbp_pkg::BIN_CONSTANT;
			for (int i = 0; i < 8; i++)
				for (int j = 1; j <= 7; j++)
					if (run_pattern(i, j, tr) == code) return 6'(i * 7 + j - 1);
			return ulbp_pkg::BIN_OTHER;
		endfunction

		static function int cell_index(int p, int c, output bit [7:0] wt);
			int num, den, q;
			num = 2 * p + 1 - c;
			den = 2 * c;
			q = num >= 0 ? num / den : -((-num + den - 1) / den);
			wt = 8'(((num - q * den) << 8) / den);
			return q;
		endfunction

		function void note_pixel(bit [15:0] pix);
			int unsigned w, h, c;
			bit [15:0] up, mid, ctr;
			bit [7:0] code;
			lbp_result_t r;
			int cx, cy;
			w = sat(width_reg, 3, 1024);
			h = sat(height_reg, 3, 4096);
			c = sat(cell_reg, 1, 256);
			up = upper_row[col_pos];
			mid = middle_row[col_pos];
			upper_row[col_pos] = mid;
			middle_row[col_pos] = pix;
			if (col_pos >= 2 && row_pos >= 2 && col_pos < w && row_pos < h) begin
				cx = cell_index(col_pos - 1, c, r.weight_col_high);
				cy = cell_index(row_pos - 1, c, r.weight_row_high);
				if (cx < int'(w / c) && cy < int'(h / c)) begin
					ctr = win[4];
					code = {up > ctr, win[3] > ctr, win[0] > ctr, win[1] > ctr,
						win[2] > ctr, win[5] > ctr, pix > ctr, mid > ctr};
					r.bin = uniform_bin(code, transposed);
					r.cell_col_low = 11'(cx);
					r.cell_row_low = 13'(cy);
					pending.push_back(r);
				end
			end
			win[0] = win[3]; win[1] = win[4]; win[2] = win[5];
			win[3] = up; win[4] = mid; win[5] = pix;
			if (col_pos + 1 >= w) begin
				col_pos = 0;
				row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
			end else begin
				col_pos++;
			end
		endfunction

		function void check_result(logic [OUT_W-1:0] data);
			lbp_result_t exp_r;
			logic [5:0] a_bin;
			logic [10:0] a_cx;
			logic [12:0] a_cy;
			logic [7:0] a_wx, a_wy;
			{a_wy, a_wx, a_cy, a_cx, a_bin} = data[45:0];
			results_seen++;
			if (pending.size() == 0) begin
				$error("result with nothing expected: %h", data);
				mismatches++;
				return;
			end
			exp_r = pending.pop_front();
			if (a_bin !== exp_r.bin) begin
				$error("bin expected %0d got %0d", exp_r.bin, a_bin); mismatches++;
			end
			if (a_cx !== exp_r.cell_col_low) begin
				$error("cell_col_low expected %0d got %0d", exp_r.cell_col_low, $signed(a_cx));
				mismatches++;
			end
			if (a_cy !== exp_r.cell_row_low) begin
				$error("cell_row_low expected %0d got %0d", exp_r.cell_row_low, $signed(a_cy));
				mismatches++;
			end
			if (a_wx !== exp_r.weight_col_high) begin
				$error("weight_col_high expected %0d got %0d", exp_r.weight_col_high, a_wx);
				mismatches++;
			end
			if (a_wy !== exp_r.weight_row_high) begin
				$error("weight_row_high expected %0d got %0d", exp_r.weight_row_high, a_wy);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [12:0] cfg_data = '0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [OUT_W-1:0] m_axis_tdata;

	lbp_scoreboard board = new();
	int unsigned pixels_sent, idle_cycles, frames_run;
	bit long_hold_req, long_hold_done;
	bit [15:0] frame_pix [$];

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	uniform_lbp_code_with_cell_weights DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Score both handshakes on the edge they complete; the sampled values are
	// the ones from before the edge, so ordering within the step does not matter.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) board.note_pixel(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver: stall on its own pattern; once, hold off for a long stretch.
	initial begin : receiver
		int unsigned phase;
		phase = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			phase++;
			if (long_hold_req && !long_hold_done) begin
				m_axis_tready <= 0;
				repeat (300) @(posedge clk);
				long_hold_done = 1;
			end
			if (phase % 512 < 128) m_axis_tready <= 1;
			else if (phase % 7 < 3) m_axis_tready <= 0;
			else m_axis_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	initial begin : watchdog
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("uniform_lbp_code_with_cell_weights_tb: errors");
				$finish;
			end
		end
	end

	// Hold valid across back-to-back writes; the caller drops it after the last.
	task automatic write_cfg(logic [7:0] idx, logic [12:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, val);
	endtask

	// Offer the queued pixels; when bursty, in bursts of random length with random gaps.
	task automatic send_frame(bit bursty);
		int burst;
		int gap;
		burst = 0;
		while (frame_pix.size() > 0) begin
			if (bursty && burst == 0) begin
				gap = $urandom_range(0, 6);
				if (gap > 0) begin
					s_axis_tvalid <= 0;
					repeat (gap) @(posedge clk);
				end
				burst = $urandom_range(1, 40);
			end
			s_axis_tvalid <= 1;
			s_axis_tdata <= frame_pix.pop_front();
			do @(posedge clk); while (!s_axis_tready);
			pixels_sent++;
			if (burst > 0) burst--;
		end
		s_axis_tvalid <= 0;
	endtask

	// Let every expected result drain, then allow the divider pipeline to settle.
	task automatic drain();
		while (board.pending.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_geometry(int w, int h, int c, bit tr);
		write_cfg(ulbp_pkg::REG_IMAGE_WIDTH, 13'(w));
		write_cfg(ulbp_pkg::REG_IMAGE_HEIGHT, 13'(h));
		write_cfg(ulbp_pkg::REG_CELL_SIZE, 13'(c));
		write_cfg(ulbp_pkg::REG_TRANSPOSED_MODE, 13'(tr));
		cfg_valid <= 0;
	endtask

	// One whole frame of random content; `style` picks the pixel distribution
	// so that ties, extremes and full 16-bit values all show up.
	task automatic random_frame(int w, int h, bit bursty);
		int style;
		style = $urandom_range(0, 3);
		for (int i = 0; i < w * h; i++)
			case (style)
				0: frame_pix.push_back(16'($urandom));
				1: frame_pix.push_back(16'($urandom_range(0, 3)));
				2: frame_pix.push_back($urandom_range(0, 1) ? 16'hffff : 16'h0000);
				default: frame_pix.push_back(16'($urandom_range(30000, 30004)));
			endcase
		send_frame(bursty);
		frames_run++;
	endtask

	initial begin : stimulus
		int w, h, c;
		board.clear();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: smallest image, then a 4x4 frame showing constant, uniform
		// and non-uniform patterns, extreme pixels, both mapping modes.
		set_geometry(3, 3, 1, 0);
		for (int i = 0; i < 9; i++) frame_pix.push_back(i == 4 ? 16'h0000 : 16'hffff);
		send_frame(0);
		drain();
		set_geometry(4, 4, 1, 1);
		for (int i = 0; i < 16; i++) frame_pix.push_back(16'((i * 40503) ^ (i << 15)));
		send_frame(0);
		drain();

		// Out-of-range values saturate: width 0 and height 0 clamp to 3, cell 0 to 1,
		// cell 511 to 256.
		set_geometry(0, 0, 0, 1);
		random_frame(3, 3, 0);
		drain();
		set_geometry(64, 3, 511, 0);
		random_frame(64, 3, 1);
		drain();

		// Pressure: keep offering pixels while the receiver holds off.
		set_geometry(16, 8, 1, 0);
		long_hold_req = 1;
		random_frame(16, 8, 0);
		drain();

		while (pixels_sent < 1950) begin
			w = $urandom_range(0, 7) == 0 ? $urandom_range(3, 64) : $urandom_range(3, 12);
			h = $urandom_range(3, 10);
			case ($urandom_range(0, 3))
				0: c = 1;
				1: c = $urandom_range(1, 4);
				2: c = $urandom_range(2, 12);
				default: c = $urandom_range(1, 300);
			endcase
			set_geometry(w, h, c, $urandom_range(0, 1));
			random_frame(w, h, 1);
			// Pause the sender until the block is empty after every frame.
			if ($urandom_range(0, 3) == 0) drain();
			else drain();
		end
		drain();

		$display("covered %0d pixels in %0d random frames, %0d results checked",
			pixels_sent, frames_run, board.results_seen);
		$display("geometry from 3x3 up to 64 wide, cell sizes 1..256, both modes");
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("uniform_lbp_code_with_cell_weights_tb: clean");
		else
			$display("uniform_lbp_code_with_cell_weights_tb: errors");
		$finish;
	end

endmodule

[filelist.f]
design/ulbp_pkg.sv
design/ulbp_front.sv
design/ulbp_queue.sv
design/ulbp_back.sv
design/uniform_lbp_code_with_cell_weights.sv
design/ulbp_checker.sv
test/uniform_lbp_code_with_cell_weights_tb.sv
